### hdl/depth_pixel_backprojection_defines.svh
// assertion macros used by the checker file
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH

// property checked at every clock edge outside reset
`define DPB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// property checked at every clock edge, reset included
`define DPB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

### hdl/dpb_pkg.sv
// shared types, constants and register codes of the depth back-projection block
`default_nettype none

package dpb_pkg;

   // frame geometry limits
   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;

   // field widths
   localparam int DEPTH_W  = 16;
   localparam int COLOR_W  = 8;
   localparam int FRAME_W  = 12;
   localparam int CENTER_W = 19;
   localparam int INV_W    = 24;
   localparam int COORD_W  = 46;
   localparam int Z_W      = 24;
   localparam int FRAC_W   = 8;

   // stream widths
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 152;

   // result word layout
   localparam int RSP_X_LSB     = 0;
   localparam int RSP_Y_LSB     = 46;
   localparam int RSP_Z_LSB     = 92;
   localparam int RSP_VALID_POS = 116;
   localparam int RSP_BLUE_LSB  = 117;
   localparam int RSP_GREEN_LSB = 125;
   localparam int RSP_RED_LSB   = 133;
   localparam int RSP_ALPHA_LSB = 141;
   localparam int RSP_USED_W    = 149;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_X     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_Y     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_INV_FOCAL_X  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_INV_FOCAL_Y  = 3'd5;

   // register reset values
   localparam logic [FRAME_W-1:0]  RST_FRAME_WIDTH  = 12'd1920;
   localparam logic [FRAME_W-1:0]  RST_FRAME_HEIGHT = 12'd1080;
   localparam logic [CENTER_W-1:0] RST_CENTER_X     = 19'd245632;
   localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 19'd138112;
   localparam logic [INV_W-1:0]    RST_INV_FOCAL_X  = 24'd15520;
   localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y  = 24'd15520;

   localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'd255;

   // product has 32 fraction bits, result keeps 8
   localparam int ROUND_SHIFT = 24;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_INV,
      ST_MUL_POS,
      ST_ROUND,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul_inv;
      logic mul_pos;
      logic round;
      logic load_out;
   } dp_cmd_type;

endpackage

`default_nettype wire

### hdl/dpb_ctrl.sv
// controller state machine: sequences one pixel through the datapath
`default_nettype none

module dpb_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output dpb_pkg::dp_cmd_type     cmd
);
   import dpb_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL_INV;
            end
         end
         ST_MUL_INV: begin
            cmd.mul_inv = 1'b1;
            state_in    = ST_MUL_POS;
         end
         ST_MUL_POS: begin
            cmd.mul_pos = 1'b1;
            state_in    = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_SEND;
         end
         ST_SEND: begin
            // output register free or being emptied this cycle
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

`default_nettype wire

### hdl/dpb_datapath.sv
// datapath: config registers, position counters, projection arithmetic, output register
`default_nettype none

module dpb_datapath #(
   parameter int MAX_WIDTH  = dpb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = dpb_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire dpb_pkg::dp_cmd_type               cmd,
   input  wire logic [dpb_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic [dpb_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_we,
   input  wire logic [dpb_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [dpb_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dpb_pkg::*;

   localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int PW    = (CW > RW) ? CW : RW;
   localparam int MW    = (PW + FRAC_W > CENTER_W) ? PW + FRAC_W : CENTER_W;
   localparam int PD_W  = INV_W + DEPTH_W;
   localparam int HALF  = PD_W / 2;
   localparam int PP_W  = MW + HALF;
   localparam int SUM_W = MW + PD_W + 1;
   localparam int R_W   = SUM_W - ROUND_SHIFT;
   localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (ROUND_SHIFT - 1);

   // configuration registers
   logic [FRAME_W-1:0]  frame_width_ff, frame_width_in;
   logic [FRAME_W-1:0]  frame_height_ff, frame_height_in;
   logic [CENTER_W-1:0] center_x_ff, center_x_in;
   logic [CENTER_W-1:0] center_y_ff, center_y_in;
   logic [INV_W-1:0]    inv_focal_x_ff, inv_focal_x_in;
   logic [INV_W-1:0]    inv_focal_y_ff, inv_focal_y_in;

   // position of the next pixel
   logic [CW-1:0] column_ff, column_in;
   logic [RW-1:0] row_ff, row_in;

   // captured pixel
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [COLOR_W-1:0] blue_ff, blue_in;
   logic [COLOR_W-1:0] green_ff, green_in;
   logic [COLOR_W-1:0] red_ff, red_in;
   logic               valid_ff, valid_in;
   logic               last_ff, last_in;
   logic [MW-1:0]      mag_x_ff, mag_x_in;
   logic [MW-1:0]      mag_y_ff, mag_y_in;
   logic               neg_x_ff, neg_x_in;
   logic               neg_y_ff, neg_y_in;

   // multiply and round stages
   logic [PD_W-1:0]    pd_x_ff, pd_x_in;
   logic [PD_W-1:0]    pd_y_ff, pd_y_in;
   logic [PP_W-1:0]    pp_x_lo_ff, pp_x_lo_in;
   logic [PP_W-1:0]    pp_x_hi_ff, pp_x_hi_in;
   logic [PP_W-1:0]    pp_y_lo_ff, pp_y_lo_in;
   logic [PP_W-1:0]    pp_y_hi_ff, pp_y_hi_in;
   logic [R_W-1:0]     r_x_ff, r_x_in;
   logic [R_W-1:0]     r_y_ff, r_y_in;

   // output register
   logic [COORD_W-1:0] point_x_ff, point_x_in;
   logic [COORD_W-1:0] point_y_ff, point_y_in;
   logic [Z_W-1:0]     point_z_ff, point_z_in;
   logic               point_valid_ff, point_valid_in;
   logic [COLOR_W-1:0] out_blue_ff, out_blue_in;
   logic [COLOR_W-1:0] out_green_ff, out_green_in;
   logic [COLOR_W-1:0] out_red_ff, out_red_in;
   logic [COLOR_W-1:0] out_alpha_ff, out_alpha_in;
   logic               frame_end_ff, frame_end_in;

   logic [CW-1:0]      column_last;
   logic [RW-1:0]      row_last_pos;
   logic               row_last;
   logic               frame_last;
   logic [MW-1:0]      scaled_x;
   logic [MW-1:0]      scaled_y;
   logic [MW-1:0]      cen_x;
   logic [MW-1:0]      cen_y;
   logic [DEPTH_W-1:0] req_depth;
   logic [SUM_W-1:0]   sum_x;
   logic [SUM_W-1:0]   sum_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
         center_x_ff     <= RST_CENTER_X;
         center_y_ff     <= RST_CENTER_Y;
         inv_focal_x_ff  <= RST_INV_FOCAL_X;
         inv_focal_y_ff  <= RST_INV_FOCAL_Y;
         column_ff       <= '0;
         row_ff          <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         center_x_ff     <= center_x_in;
         center_y_ff     <= center_y_in;
         inv_focal_x_ff  <= inv_focal_x_in;
         inv_focal_y_ff  <= inv_focal_y_in;
         column_ff       <= column_in;
         row_ff          <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      depth_ff       <= depth_in;
      blue_ff        <= blue_in;
      green_ff       <= green_in;
      red_ff         <= red_in;
      valid_ff       <= valid_in;
      last_ff        <= last_in;
      mag_x_ff       <= mag_x_in;
      mag_y_ff       <= mag_y_in;
      neg_x_ff       <= neg_x_in;
      neg_y_ff       <= neg_y_in;
      pd_x_ff        <= pd_x_in;
      pd_y_ff        <= pd_y_in;
      pp_x_lo_ff     <= pp_x_lo_in;
      pp_x_hi_ff     <= pp_x_hi_in;
      pp_y_lo_ff     <= pp_y_lo_in;
      pp_y_hi_ff     <= pp_y_hi_in;
      r_x_ff         <= r_x_in;
      r_y_ff         <= r_y_in;
      point_x_ff     <= point_x_in;
      point_y_ff     <= point_y_in;
      point_z_ff     <= point_z_in;
      point_valid_ff <= point_valid_in;
      out_blue_ff    <= out_blue_in;
      out_green_ff   <= out_green_in;
      out_red_ff     <= out_red_in;
      out_alpha_ff   <= out_alpha_in;
      frame_end_ff   <= frame_end_in;
   end

   // register writes
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      center_x_in     = center_x_ff;
      center_y_in     = center_y_ff;
      inv_focal_x_in  = inv_focal_x_ff;
      inv_focal_y_in  = inv_focal_y_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata[FRAME_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata[FRAME_W-1:0];
            CSR_CENTER_X:     center_x_in     = csr_wdata[CENTER_W-1:0];
            CSR_CENTER_Y:     center_y_in     = csr_wdata[CENTER_W-1:0];
            CSR_INV_FOCAL_X:  inv_focal_x_in  = csr_wdata[INV_W-1:0];
            CSR_INV_FOCAL_Y:  inv_focal_y_in  = csr_wdata[INV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // last position of each extent: zero acts as one, oversize clamps to the maximum
   always_comb begin
      if (frame_width_ff == '0) begin
         column_last = '0;
      end else if (int'(frame_width_ff) > MAX_WIDTH) begin
         column_last = CW'(MAX_WIDTH - 1);
      end else begin
         column_last = CW'(frame_width_ff - FRAME_W'(1));
      end
      if (frame_height_ff == '0) begin
         row_last_pos = '0;
      end else if (int'(frame_height_ff) > MAX_HEIGHT) begin
         row_last_pos = RW'(MAX_HEIGHT - 1);
      end else begin
         row_last_pos = RW'(frame_height_ff - FRAME_W'(1));
      end
   end

   assign row_last   = column_ff >= column_last;
   assign frame_last = row_ff >= row_last_pos;

   assign scaled_x  = MW'({column_ff, {FRAC_W{1'b0}}});
   assign scaled_y  = MW'({row_ff, {FRAC_W{1'b0}}});
   assign cen_x     = MW'(center_x_ff);
   assign cen_y     = MW'(center_y_ff);
   assign req_depth = req_tdata[DEPTH_W-1:0];

   // capture and counter step
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      depth_in  = depth_ff;
      blue_in   = blue_ff;
      green_in  = green_ff;
      red_in    = red_ff;
      valid_in  = valid_ff;
      last_in   = last_ff;
      mag_x_in  = mag_x_ff;
      mag_y_in  = mag_y_ff;
      neg_x_in  = neg_x_ff;
      neg_y_in  = neg_y_ff;
      if (cmd.capture) begin
         depth_in = req_depth;
         valid_in = req_depth != '0;
         if (req_depth != '0) begin
            blue_in  = req_tdata[23:16];
            green_in = req_tdata[31:24];
            red_in   = req_tdata[39:32];
         end else begin
            blue_in  = '0;
            green_in = '0;
            red_in   = '0;
         end
         last_in  = row_last && frame_last;
         neg_x_in = cen_x > scaled_x;
         neg_y_in = cen_y > scaled_y;
         mag_x_in = (cen_x > scaled_x) ? (cen_x - scaled_x) : (scaled_x - cen_x);
         mag_y_in = (cen_y > scaled_y) ? (cen_y - scaled_y) : (scaled_y - cen_y);
         if (row_last) begin
            column_in = '0;
            row_in    = frame_last ? '0 : row_ff + RW'(1);
         end else begin
            column_in = column_ff + CW'(1);
         end
      end
   end

   // inverse focal times depth, then magnitude times that in two halves
   always_comb begin
      pd_x_in    = pd_x_ff;
      pd_y_in    = pd_y_ff;
      pp_x_lo_in = pp_x_lo_ff;
      pp_x_hi_in = pp_x_hi_ff;
      pp_y_lo_in = pp_y_lo_ff;
      pp_y_hi_in = pp_y_hi_ff;
      if (cmd.mul_inv) begin
         pd_x_in = PD_W'(inv_focal_x_ff) * PD_W'(depth_ff);
         pd_y_in = PD_W'(inv_focal_y_ff) * PD_W'(depth_ff);
      end
      if (cmd.mul_pos) begin
         pp_x_lo_in = PP_W'(mag_x_ff) * PP_W'(pd_x_ff[HALF-1:0]);
         pp_x_hi_in = PP_W'(mag_x_ff) * PP_W'(pd_x_ff[PD_W-1:HALF]);
         pp_y_lo_in = PP_W'(mag_y_ff) * PP_W'(pd_y_ff[HALF-1:0]);
         pp_y_hi_in = PP_W'(mag_y_ff) * PP_W'(pd_y_ff[PD_W-1:HALF]);
      end
   end

   // round to nearest, ties away from zero (applied to the magnitude)
   assign sum_x = SUM_W'(pp_x_lo_ff) + (SUM_W'(pp_x_hi_ff) << HALF) + ROUND_BIAS;
   assign sum_y = SUM_W'(pp_y_lo_ff) + (SUM_W'(pp_y_hi_ff) << HALF) + ROUND_BIAS;

   always_comb begin
      r_x_in = r_x_ff;
      r_y_in = r_y_ff;
      if (cmd.round) begin
         r_x_in = sum_x[SUM_W-1:ROUND_SHIFT];
         r_y_in = sum_y[SUM_W-1:ROUND_SHIFT];
      end
   end

   always_comb begin
      point_x_in     = point_x_ff;
      point_y_in     = point_y_ff;
      point_z_in     = point_z_ff;
      point_valid_in = point_valid_ff;
      out_blue_in    = out_blue_ff;
      out_green_in   = out_green_ff;
      out_red_in     = out_red_ff;
      out_alpha_in   = out_alpha_ff;
      frame_end_in   = frame_end_ff;
      if (cmd.load_out) begin
         point_x_in     = neg_x_ff ? (COORD_W'(0) - COORD_W'(r_x_ff)) : COORD_W'(r_x_ff);
         point_y_in     = neg_y_ff ? (COORD_W'(0) - COORD_W'(r_y_ff)) : COORD_W'(r_y_ff);
         point_z_in     = {depth_ff, {FRAC_W{1'b0}}};
         point_valid_in = valid_ff;
         out_blue_in    = blue_ff;
         out_green_in   = green_ff;
         out_red_in     = red_ff;
         out_alpha_in   = valid_ff ? ALPHA_OPAQUE : '0;
         frame_end_in   = last_ff;
      end
   end

   assign rsp_tdata = {
      {(RSP_TDATA_W - RSP_USED_W){1'b0}},
      out_alpha_ff,
      out_red_ff,
      out_green_ff,
      out_blue_ff,
      point_valid_ff,
      point_z_ff,
      point_y_ff,
      point_x_ff
   };
   assign rsp_tlast = frame_end_ff;

endmodule

`default_nettype wire

### hdl/depth_pixel_backprojection.sv
// top level: pinhole back-projection of depth and colour pixels into 3D points
//
//   port group   dir   carries
//   req_*        in    one pixel word: depth and colour
//   rsp_*        out   one point word: coordinates, valid, colour, alpha; tlast ends a frame
//   csr_*        in    register writes, no read-back
//
// each word passes through the steps capture at acceptance, inverse focal times
// depth, position times that product, rounding and output load; the point shows on rsp
// after its output load, and the next word is taken only once the last one is loaded,
// so the next word is taken while a finished point still waits in the output register
// a stalled rsp side holds the block in its output step until the register frees up
// synchronous active-high reset restores the register defaults and zeroes the counters
`default_nettype none

module depth_pixel_backprojection #(
   parameter int MAX_WIDTH  = dpb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = dpb_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // depth_mm[15:0], blue[23:16], green[31:24], red[39:32]
   input  wire logic [dpb_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // point_x[45:0], point_y[91:46], point_z[115:92], point_valid[116],
   // out_blue[124:117], out_green[132:125], out_red[140:133], out_alpha[148:141]
   output logic [dpb_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_we,
   input  wire logic [dpb_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [dpb_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dpb_pkg::*;

   dp_cmd_type cmd;

   dpb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   dpb_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

endmodule

`default_nettype wire

### hdl/dpb_checker.sv
// port-level checker for the back-projection block and its bind
`default_nettype none

`include "depth_pixel_backprojection_defines.svh"

module dpb_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [dpb_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready
);
   import dpb_pkg::*;

   logic               pt_valid;
   logic [COLOR_W-1:0] pt_alpha;
   logic [FRAC_W-1:0]  pt_z_frac;

   assign pt_valid  = rsp_tdata[RSP_VALID_POS];
   assign pt_alpha  = rsp_tdata[RSP_ALPHA_LSB +: COLOR_W];
   assign pt_z_frac = rsp_tdata[RSP_Z_LSB +: FRAC_W];

   `DPB_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result word dropped while stalled")
   `DPB_ASSERT(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready, "word taken while one is in flight")
   `DPB_ASSERT(a_invalid_zero, clock, reset, rsp_tvalid && !pt_valid |-> rsp_tdata == '0, "invalid point carries nonzero payload")
   `DPB_ASSERT(a_valid_point, clock, reset, rsp_tvalid && pt_valid |-> pt_alpha == ALPHA_OPAQUE && pt_z_frac == '0, "valid point with bad alpha or depth fraction")
   `DPB_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) && !reset |-> !rsp_tvalid && req_tready, "block not idle after reset")

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (.*);

`default_nettype wire
